### rtl/mspid_pkg.sv
// ----------------------------------------------------------------------------
// Motor speed PID package
// Shared types and fixed constants of the four-channel motor speed PID block.
// ----------------------------------------------------------------------------
package mspid_pkg;

   typedef logic [15:0] gain_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [63:0] csr_data_type;

   localparam csr_index_type CSR_PROP_GAINS  = 2'd0;
   localparam csr_index_type CSR_INTEG_GAINS = 2'd1;
   localparam csr_index_type CSR_DERIV_GAINS = 2'd2;

   localparam csr_data_type PROP_GAINS_RESET  = 64'd1037532595659935130;
   localparam csr_data_type INTEG_GAINS_RESET = 64'd23081265923227709;
   localparam csr_data_type DERIV_GAINS_RESET = 64'd0;

   localparam int GAIN_WIDTH  = 16;
   localparam int SPEED_WIDTH = 16;
   localparam int ERR_WIDTH   = 17;
   localparam int D2_WIDTH    = 19;
   localparam int DRIVE_WIDTH = 16;
   localparam int DRIVE_LIMIT = 32767;

   // Division of a 17-bit magnitude by ten as a multiply by 0xCCCD and a shift.
   localparam logic [15:0] SPEED_RECIP       = 16'hCCCD;
   localparam int          SPEED_RECIP_SHIFT = 19;
   localparam int          MEAS_QUOT_WIDTH   = 12;
   localparam int          MEAS_WIDTH        = 13;

endpackage

### rtl/mspid_ram.sv
// ----------------------------------------------------------------------------
// Motor speed PID state RAM
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module mspid_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 4,
   parameter int ADDR_WIDTH = 2
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/four_channel_motor_speed_pid_top.sv
// ----------------------------------------------------------------------------
// Four-channel motor speed PID controller
// Incremental PID speed loop for up to four motor channels, state kept in RAM.
// ----------------------------------------------------------------------------
// An item on the req_ channel names a motor channel and carries a target speed
// and a raw encoder speed. The block returns one item on the rsp_ channel with
// the new drive command of that channel and a flag that is set when the error
// sum or the drive was clamped. Gains are written through the csr_ port, which
// is ready whenever reset is low; writes are meant to happen while no item is
// in flight. The per-channel state (error sum, two past errors, drive) lives
// in one RAM. An item is read from the RAM when it is accepted, passes an error
// stage, a multiply stage and an accumulate stage, and is written back as it
// moves into the output register. Items for different channels are taken one
// per cycle while rsp_stall does not hold the stages. An item whose channel
// is still in one of the three stages is held off until the earlier item of
// that channel has been written back, as the read-modify-write loop through
// the RAM needs the new state. When rsp_stall is high the output register
// holds its item while the stages behind it keep filling. Reset loads the
// default gains, stalls both input channels and marks every channel's state
// as zero at once.
// ----------------------------------------------------------------------------
module four_channel_motor_speed_pid_top
   import mspid_pkg::*;
#(
   parameter int CHANNELS       = 4,
   parameter int GAIN_FRAC_BITS = 12,
   parameter int SUM_WIDTH      = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_channel,
   input  logic signed [15:0]        req_target_speed,
   input  logic signed [15:0]        req_measured_speed,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_channel_out,
   output logic signed [15:0]        rsp_drive_value,
   output logic                      rsp_saturated,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csr_index_type             csr_index,
   input  csr_data_type              csr_data
);

   localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_EXT  = SUM_WIDTH + 1;
   localparam int WW       = SUM_WIDTH + ERR_WIDTH + ERR_WIDTH + DRIVE_WIDTH;
   localparam int BL_LO    = DRIVE_WIDTH;
   localparam int LAST_LO  = DRIVE_WIDTH + ERR_WIDTH;
   localparam int SUM_LO   = DRIVE_WIDTH + ERR_WIDTH + ERR_WIDTH;
   localparam int PI_WIDTH = SUM_WIDTH + GAIN_WIDTH + 1;
   localparam int PP_WIDTH = ERR_WIDTH + GAIN_WIDTH + 1;
   localparam int PD_WIDTH = D2_WIDTH + GAIN_WIDTH + 1;
   localparam int TW       = ((PI_WIDTH > PD_WIDTH) ? PI_WIDTH : PD_WIDTH) + 2;
   localparam logic signed [SUM_EXT-1:0] SUM_LIM =
      SUM_EXT'((64'd1 << (SUM_WIDTH - 1)) - 64'd1);
   localparam logic signed [TW-1:0] DRIVE_LIM = TW'(DRIVE_LIMIT);

   // Configuration
   csr_data_type prop_gains_ff, integ_gains_ff, deriv_gains_ff;

   // Per-channel state validity
   logic [CHANNELS-1:0] entry_valid_ff;
   logic [CHANNELS-1:0] entry_valid_in;

   // Handshake and pipeline control
   logic out_free, s3_go, s3_ready, s2_go, s2_ready, s1_go, s1_ready;
   logic hazard, accept, req_in_range;
   logic [AW-1:0] rd_addr, wr_addr;

   // Accept stage
   logic signed [16:0]                 meas_ext;
   logic [16:0]                        meas_mag;
   logic [32:0]                        meas_prod;
   logic [MEAS_QUOT_WIDTH-1:0]         meas_quot;
   logic signed [MEAS_WIDTH-1:0]       s1_meas_in;

   // Error stage
   logic                               s1_valid_ff, s1_in_range_ff, s1_known_ff;
   logic [1:0]                         s1_channel_ff;
   logic [AW-1:0]                      s1_addr_ff;
   logic signed [15:0]                 s1_target_ff;
   logic signed [MEAS_WIDTH-1:0]       s1_meas_ff;
   logic [WW-1:0]                      ram_rd_data, ram_word, ram_wr_data;
   logic signed [SUM_WIDTH-1:0]        old_sum;
   logic signed [ERR_WIDTH-1:0]        old_last, old_bl;
   logic signed [DRIVE_WIDTH-1:0]      old_drive;
   logic signed [SUM_EXT-1:0]          sum_raw;
   logic                               sum_over, sum_under;
   logic [5:0]                         gain_lo;

   // Multiply stage
   logic                               s2_valid_ff, s2_in_range_ff, s2_sat_ff, s2_sat_in;
   logic [1:0]                         s2_channel_ff;
   logic [AW-1:0]                      s2_addr_ff;
   logic signed [ERR_WIDTH-1:0]        s2_err_ff, s2_err_in, s2_last_ff;
   logic signed [SUM_WIDTH-1:0]        s2_sum_ff, s2_sum_in;
   logic signed [D2_WIDTH-1:0]         s2_d2_ff, s2_d2_in;
   logic signed [DRIVE_WIDTH-1:0]      s2_drive_ff;
   gain_type                           s2_kp_ff, s2_ki_ff, s2_kd_ff;
   gain_type                           s2_kp_in, s2_ki_in, s2_kd_in;

   // Accumulate stage
   logic                               s3_valid_ff, s3_in_range_ff, s3_sat_ff;
   logic [1:0]                         s3_channel_ff;
   logic [AW-1:0]                      s3_addr_ff;
   logic signed [ERR_WIDTH-1:0]        s3_err_ff, s3_last_ff;
   logic signed [SUM_WIDTH-1:0]        s3_sum_ff;
   logic signed [DRIVE_WIDTH-1:0]      s3_drive_ff;
   logic signed [PP_WIDTH-1:0]         s3_prod_p_ff, s3_prod_p_in;
   logic signed [PI_WIDTH-1:0]         s3_prod_i_ff, s3_prod_i_in;
   logic signed [PD_WIDTH-1:0]         s3_prod_d_ff, s3_prod_d_in;
   logic signed [TW-1:0]               total, quo_floor, quo;
   logic                               round_up, drive_over, drive_under, ram_wr_en;
   logic signed [DRIVE_WIDTH-1:0]      drive_new;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in, rsp_sat_ff, rsp_sat_in;
   logic [1:0]                         rsp_channel_ff;
   logic signed [DRIVE_WIDTH-1:0]      rsp_drive_ff, rsp_drive_in;
   logic                               s1_valid_in, s2_valid_in, s3_valid_in;

   // ------------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------------
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      s3_ready = !s3_valid_ff || out_free;
      s3_go    = s3_valid_ff && out_free;
      s2_ready = !s2_valid_ff || s3_ready;
      s2_go    = s2_valid_ff && s3_ready;
      s1_ready = !s1_valid_ff || s2_ready;
      s1_go    = s1_valid_ff && s2_ready;
      hazard   = (s1_valid_ff && (s1_channel_ff == req_channel)) ||
                 (s2_valid_ff && (s2_channel_ff == req_channel)) ||
                 (s3_valid_ff && (s3_channel_ff == req_channel));
      accept   = req_valid && s1_ready && !hazard;
      s1_valid_in  = accept || (s1_valid_ff && !s1_go);
      s2_valid_in  = s1_go || (s2_valid_ff && !s2_go);
      s3_valid_in  = s2_go || (s3_valid_ff && !s3_go);
      rsp_valid_in = s3_go || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall       = reset || !s1_ready || hazard;
   assign csr_ready       = !reset;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_drive_value = rsp_drive_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // ------------------------------------------------------------------------
   // Accept stage: RAM read and measured speed divided by ten
   // ------------------------------------------------------------------------
   always_comb begin
      req_in_range = int'(req_channel) < CHANNELS;
      rd_addr      = AW'(req_channel);
      meas_ext     = {req_measured_speed[15], req_measured_speed};
      meas_mag     = meas_ext[16] ? 17'(-meas_ext) : 17'(meas_ext);
      meas_prod    = 33'(meas_mag) * 33'(SPEED_RECIP);
      meas_quot    = meas_prod[SPEED_RECIP_SHIFT +: MEAS_QUOT_WIDTH];
      s1_meas_in   = meas_ext[16] ? -$signed({1'b0, meas_quot})
                                  : $signed({1'b0, meas_quot});
   end

   mspid_ram #(
      .WIDTH      (WW),
      .DEPTH      (CHANNELS),
      .ADDR_WIDTH (AW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Error stage: error, clamped sum, second difference, gain selection
   // ------------------------------------------------------------------------
   always_comb begin
      ram_word  = s1_known_ff ? ram_rd_data : '0;
      old_drive = ram_word[DRIVE_WIDTH-1:0];
      old_bl    = ram_word[BL_LO +: ERR_WIDTH];
      old_last  = ram_word[LAST_LO +: ERR_WIDTH];
      old_sum   = ram_word[SUM_LO +: SUM_WIDTH];
      s2_err_in = ERR_WIDTH'(s1_target_ff) - ERR_WIDTH'(s1_meas_ff);
      sum_raw   = SUM_EXT'(old_sum) + SUM_EXT'(s2_err_in);
      sum_over  = sum_raw > SUM_LIM;
      sum_under = sum_raw < -SUM_LIM;
      if (sum_over) begin
         s2_sum_in = SUM_WIDTH'(SUM_LIM);
      end else if (sum_under) begin
         s2_sum_in = SUM_WIDTH'(-SUM_LIM);
      end else begin
         s2_sum_in = SUM_WIDTH'(sum_raw);
      end
      s2_sat_in = sum_over || sum_under;
      s2_d2_in  = D2_WIDTH'(s2_err_in) - (D2_WIDTH'(old_last) <<< 1) + D2_WIDTH'(old_bl);
      gain_lo   = {s1_channel_ff, 4'b0000};
      s2_kp_in  = prop_gains_ff[gain_lo +: GAIN_WIDTH];
      s2_ki_in  = integ_gains_ff[gain_lo +: GAIN_WIDTH];
      s2_kd_in  = deriv_gains_ff[gain_lo +: GAIN_WIDTH];
   end

   // ------------------------------------------------------------------------
   // Multiply stage
   // ------------------------------------------------------------------------
   always_comb begin
      s3_prod_p_in = $signed({1'b0, s2_kp_ff}) * s2_err_ff;
      s3_prod_i_in = $signed({1'b0, s2_ki_ff}) * s2_sum_ff;
      s3_prod_d_in = $signed({1'b0, s2_kd_ff}) * s2_d2_ff;
   end

   // ------------------------------------------------------------------------
   // Accumulate stage: new drive, truncated toward zero and clamped
   // ------------------------------------------------------------------------
   always_comb begin
      total     = (TW'(s3_drive_ff) <<< GAIN_FRAC_BITS) + TW'(s3_prod_p_ff)
                + TW'(s3_prod_i_ff) + TW'(s3_prod_d_ff);
      quo_floor = total >>> GAIN_FRAC_BITS;
      round_up  = total[TW-1] && (|total[GAIN_FRAC_BITS-1:0]);
      quo       = round_up ? quo_floor + TW'(1) : quo_floor;
      drive_over  = quo > DRIVE_LIM;
      drive_under = quo < -DRIVE_LIM;
      if (drive_over) begin
         drive_new = DRIVE_WIDTH'(DRIVE_LIM);
      end else if (drive_under) begin
         drive_new = DRIVE_WIDTH'(-DRIVE_LIM);
      end else begin
         drive_new = DRIVE_WIDTH'(quo);
      end
      ram_wr_en    = s3_go && s3_in_range_ff;
      wr_addr      = s3_addr_ff;
      ram_wr_data  = {s3_sum_ff, s3_err_ff, s3_last_ff, drive_new};
      rsp_drive_in = s3_in_range_ff ? drive_new : '0;
      rsp_sat_in   = s3_in_range_ff && (s3_sat_ff || drive_over || drive_under);
      entry_valid_in = entry_valid_ff;
      if (ram_wr_en) begin
         entry_valid_in[wr_addr] = 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gains_ff  <= PROP_GAINS_RESET;
         integ_gains_ff <= INTEG_GAINS_RESET;
         deriv_gains_ff <= DERIV_GAINS_RESET;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROP_GAINS:  prop_gains_ff  <= csr_data;
               CSR_INTEG_GAINS: integ_gains_ff <= csr_data;
               CSR_DERIV_GAINS: deriv_gains_ff <= csr_data;
               default: ;
            endcase
         end
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s3_valid_ff    <= s3_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_channel_ff  <= req_channel;
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= req_in_range;
         s1_known_ff    <= req_in_range && entry_valid_ff[rd_addr];
         s1_target_ff   <= req_target_speed;
         s1_meas_ff     <= s1_meas_in;
      end
      if (s1_go) begin
         s2_channel_ff  <= s1_channel_ff;
         s2_addr_ff     <= s1_addr_ff;
         s2_in_range_ff <= s1_in_range_ff;
         s2_sat_ff      <= s2_sat_in;
         s2_err_ff      <= s2_err_in;
         s2_sum_ff      <= s2_sum_in;
         s2_d2_ff       <= s2_d2_in;
         s2_last_ff     <= old_last;
         s2_drive_ff    <= old_drive;
         s2_kp_ff       <= s2_kp_in;
         s2_ki_ff       <= s2_ki_in;
         s2_kd_ff       <= s2_kd_in;
      end
      if (s2_go) begin
         s3_channel_ff  <= s2_channel_ff;
         s3_addr_ff     <= s2_addr_ff;
         s3_in_range_ff <= s2_in_range_ff;
         s3_sat_ff      <= s2_sat_ff;
         s3_err_ff      <= s2_err_ff;
         s3_sum_ff      <= s2_sum_ff;
         s3_last_ff     <= s2_last_ff;
         s3_drive_ff    <= s2_drive_ff;
         s3_prod_p_ff   <= s3_prod_p_in;
         s3_prod_i_ff   <= s3_prod_i_in;
         s3_prod_d_ff   <= s3_prod_d_in;
      end
      if (s3_go) begin
         rsp_channel_ff <= s3_channel_ff;
         rsp_drive_ff   <= rsp_drive_in;
         rsp_sat_ff     <= rsp_sat_in;
      end
   end

endmodule
